// File: rtl/gba_pkg.sv
// Shared types and constants for the glyph blit and alpha blend block.
`timescale 1ns / 1ps

package gba_pkg;

    localparam int C_POS_W      = 12;
    localparam int C_CFG_DATA_W = 17;

    localparam logic [15:0] C_FG_RESET  = 16'hFFFF;
    localparam logic [16:0] C_ALPHA_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REQ_GLYPH_START = 2'd0,
        REQ_BITMAP_WORD = 2'd1,
        REQ_PIXEL_WRITE = 2'd2,
        REQ_PIXEL_READ  = 2'd3
    } t_req_type;

    typedef enum logic [0:0] {
        CFG_FG_COLOR = 1'b0,
        CFG_FG_ALPHA = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_BLEND,
        ST_WRITE,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic step;
        logic paint_wr;
        logic blend_rd;
        logic blend_wr;
        logic pix_wr;
        logic pix_rd;
        logic rsp_load;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic bit_set;
        logic visible;
        logic opaque;
        logic last_bit;
        logic finish;
    } t_status;

endpackage

// File: rtl/gba_req_if.sv
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps

interface gba_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [9:0]  glyph_x;
    logic signed [9:0]  glyph_y;
    logic [4:0]         glyph_width;
    logic [4:0]         glyph_height;
    logic [31:0]        bitmap_word;
    logic [12:0]        pixel_addr;
    logic [15:0]        pixel_value;

    modport source (
        output valid, req_type, glyph_x, glyph_y, glyph_width, glyph_height,
               bitmap_word, pixel_addr, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, glyph_x, glyph_y, glyph_width, glyph_height,
               bitmap_word, pixel_addr, pixel_value,
        output ready
    );
endinterface

// File: rtl/gba_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface gba_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        glyph_done;
    logic        word_ignored;

    modport source (
        output valid, read_data, glyph_done, word_ignored,
        input  ready
    );

    modport sink (
        input  valid, read_data, glyph_done, word_ignored,
        output ready
    );
endinterface

// File: rtl/gba_datapath.sv
// Datapath: fragment buffer memory, glyph cursor, blend arithmetic and result register.
`timescale 1ns / 1ps

module gba_datapath #(
    parameter int FRAG_WIDTH  = 240,
    parameter int FRAG_HEIGHT = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [gba_pkg::C_CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                        i_req_type,
    input  logic signed [9:0]                 i_glyph_x,
    input  logic signed [9:0]                 i_glyph_y,
    input  logic [4:0]                        i_glyph_width,
    input  logic [4:0]                        i_glyph_height,
    input  logic [31:0]                       i_bitmap_word,
    input  logic [12:0]                       i_pixel_addr,
    input  logic [15:0]                       i_pixel_value,
    input  gba_pkg::t_cmd                     i_cmd,
    output gba_pkg::t_status                  o_sts,
    output logic [15:0]                       o_read_data,
    output logic                              o_glyph_done,
    output logic                              o_word_ignored
);

    localparam int DEPTH  = FRAG_WIDTH * FRAG_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = ADDR_W + 14;
    localparam int POS_W  = gba_pkg::C_POS_W;
    localparam logic signed [POS_W-1:0] C_W_LIM = POS_W'(FRAG_WIDTH);
    localparam logic signed [POS_W-1:0] C_H_LIM = POS_W'(FRAG_HEIGHT);

    logic [15:0] r_mem [DEPTH];

    logic [15:0]               r_fg;
    logic [16:0]               r_alpha;
    logic                      r_active;
    logic [4:0]                r_col;
    logic [4:0]                r_row;
    logic [4:0]                r_bit_cnt;
    logic                      r_done;
    logic                      r_ignored;
    gba_pkg::t_req_type        r_req_type;
    logic signed [POS_W-1:0]   r_org_x;
    logic signed [POS_W-1:0]   r_tx;
    logic signed [POS_W-1:0]   r_ty;
    logic [4:0]                r_size_w;
    logic [4:0]                r_size_h;
    logic [31:0]               r_word;
    logic [12:0]               r_addr;
    logic [15:0]               r_value;
    logic [15:0]               r_rdata;
    logic [15:0]               r_out_data;
    logic                      r_out_done;
    logic                      r_out_ign;

    gba_pkg::t_req_type        req_type;
    logic                      addr_ok;
    logic                      col_wrap;
    logic                      row_wrap;
    logic                      visible;
    logic [ADDR_W-1:0]         pix_idx;
    logic [16:0]               inv_alpha;
    logic [23:0]               sum_r;
    logic [23:0]               sum_g;
    logic [23:0]               sum_b;
    logic [15:0]               blended;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [15:0]               mem_wdata;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;

    assign req_type = gba_pkg::t_req_type'(i_req_type);
    assign addr_ok  = {{(CMP_W-13){1'b0}}, r_addr} < CMP_W'(DEPTH);
    assign col_wrap = ({1'b0, r_col} + 6'd1) >= {1'b0, r_size_w};
    assign row_wrap = ({1'b0, r_row} + 6'd1) >= {1'b0, r_size_h};
    assign visible  = !r_tx[POS_W-1] && (r_tx < C_W_LIM)
                   && !r_ty[POS_W-1] && (r_ty < C_H_LIM);
    assign pix_idx  = ADDR_W'($unsigned(r_ty)) * ADDR_W'(FRAG_WIDTH)
                    + ADDR_W'($unsigned(r_tx));

    assign inv_alpha = gba_pkg::C_ALPHA_ONE - r_alpha;
    assign sum_r = 24'(r_fg[15:11]) * 24'(r_alpha) + 24'(r_rdata[15:11]) * 24'(inv_alpha);
    assign sum_g = 24'(r_fg[10:5]) * 24'(r_alpha) + 24'(r_rdata[10:5]) * 24'(inv_alpha);
    assign sum_b = 24'(r_fg[4:0]) * 24'(r_alpha) + 24'(r_rdata[4:0]) * 24'(inv_alpha);
    assign blended = {sum_r[20:16], sum_g[21:16], sum_b[20:16]};

    always_comb begin
        o_sts.active   = r_active;
        o_sts.bit_set  = r_word[31];
        o_sts.visible  = visible;
        o_sts.opaque   = r_alpha[16];
        o_sts.last_bit = &r_bit_cnt;
        o_sts.finish   = col_wrap && row_wrap;
    end

    always_comb begin
        mem_we    = (i_cmd.pix_wr && addr_ok) || i_cmd.paint_wr || i_cmd.blend_wr;
        mem_waddr = i_cmd.pix_wr ? ADDR_W'(r_addr) : pix_idx;
        mem_wdata = r_fg;
        if (i_cmd.pix_wr) begin
            mem_wdata = r_value;
        end else if (i_cmd.blend_wr) begin
            mem_wdata = blended;
        end
        mem_re    = (i_cmd.pix_rd && addr_ok) || i_cmd.blend_rd;
        mem_raddr = i_cmd.pix_rd ? ADDR_W'(r_addr) : pix_idx;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg      <= gba_pkg::C_FG_RESET;
            r_alpha   <= gba_pkg::C_ALPHA_ONE;
            r_active  <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_bit_cnt <= '0;
            r_done    <= 1'b0;
            r_ignored <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (gba_pkg::t_cfg_idx'(i_cfg_idx))
                    gba_pkg::CFG_FG_COLOR: r_fg <= i_cfg_data[15:0];
                    gba_pkg::CFG_FG_ALPHA: r_alpha <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_done    <= 1'b0;
                r_ignored <= (req_type == gba_pkg::REQ_BITMAP_WORD) && !r_active;
                case (req_type)
                    gba_pkg::REQ_GLYPH_START: begin
                        r_col    <= '0;
                        r_row    <= '0;
                        r_active <= (i_glyph_width != '0) && (i_glyph_height != '0);
                    end
                    gba_pkg::REQ_BITMAP_WORD: begin
                        r_bit_cnt <= '0;
                    end
                    default: ;
                endcase
            end else if (i_cmd.step) begin
                r_bit_cnt <= r_bit_cnt + 5'd1;
                if (col_wrap) begin
                    r_col <= '0;
                    if (row_wrap) begin
                        r_row    <= '0;
                        r_active <= 1'b0;
                        r_done   <= 1'b1;
                    end else begin
                        r_row <= r_row + 5'd1;
                    end
                end else begin
                    r_col <= r_col + 5'd1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= req_type;
            r_addr     <= i_pixel_addr;
            r_value    <= i_pixel_value;
            r_word     <= i_bitmap_word;
            if (req_type == gba_pkg::REQ_GLYPH_START) begin
                r_org_x  <= {{(POS_W-10){i_glyph_x[9]}}, i_glyph_x};
                r_tx     <= {{(POS_W-10){i_glyph_x[9]}}, i_glyph_x};
                r_ty     <= {{(POS_W-10){i_glyph_y[9]}}, i_glyph_y};
                r_size_w <= i_glyph_width;
                r_size_h <= i_glyph_height;
            end
        end else if (i_cmd.step) begin
            r_word <= {r_word[30:0], 1'b0};
            if (col_wrap) begin
                r_tx <= r_org_x;
                r_ty <= r_ty + POS_W'(1);
            end else begin
                r_tx <= r_tx + POS_W'(1);
            end
        end
        if (i_cmd.rsp_load) begin
            r_out_data <= (r_req_type == gba_pkg::REQ_PIXEL_READ && addr_ok) ? r_rdata : '0;
            r_out_done <= r_done;
            r_out_ign  <= r_ignored;
        end
    end

    assign o_read_data    = r_out_data;
    assign o_glyph_done   = r_out_done;
    assign o_word_ignored = r_out_ign;

endmodule

// File: rtl/gba_ctrl.sv
// Controller: sequences each request through the datapath and owns the handshakes.
`timescale 1ns / 1ps

module gba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [1:0]        i_req_type,
    input  logic              i_rsp_ready,
    input  gba_pkg::t_status  i_sts,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    output gba_pkg::t_cmd     o_cmd
);

    gba_pkg::t_state r_state;
    gba_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gba_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            gba_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    case (gba_pkg::t_req_type'(i_req_type))
                        gba_pkg::REQ_BITMAP_WORD:
                            n_state = i_sts.active ? gba_pkg::ST_BIT : gba_pkg::ST_RESP;
                        gba_pkg::REQ_PIXEL_WRITE: n_state = gba_pkg::ST_WRITE;
                        gba_pkg::REQ_PIXEL_READ:  n_state = gba_pkg::ST_READ;
                        default:                  n_state = gba_pkg::ST_RESP;
                    endcase
                end
            end
            gba_pkg::ST_BIT: begin
                if (i_sts.bit_set && i_sts.visible && !i_sts.opaque) begin
                    o_cmd.blend_rd = 1'b1;
                    n_state        = gba_pkg::ST_BLEND;
                end else begin
                    o_cmd.paint_wr = i_sts.bit_set && i_sts.visible;
                    o_cmd.step     = 1'b1;
                    if (i_sts.finish || i_sts.last_bit) begin
                        n_state = gba_pkg::ST_RESP;
                    end
                end
            end
            gba_pkg::ST_BLEND: begin
                o_cmd.blend_wr = 1'b1;
                o_cmd.step     = 1'b1;
                n_state = (i_sts.finish || i_sts.last_bit) ? gba_pkg::ST_RESP
                                                           : gba_pkg::ST_BIT;
            end
            gba_pkg::ST_WRITE: begin
                o_cmd.pix_wr = 1'b1;
                n_state      = gba_pkg::ST_RESP;
            end
            gba_pkg::ST_READ: begin
                o_cmd.pix_rd = 1'b1;
                n_state      = gba_pkg::ST_RESP;
            end
            gba_pkg::ST_RESP: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.rsp_load = 1'b1;
                    n_state        = gba_pkg::ST_IDLE;
                end
            end
            default: n_state = gba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.rsp_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

// File: rtl/glyph_blit_alpha_blend.sv
// Top level: glyph blit with alpha blend into an RGB565 fragment buffer.
//
// Requests are taken one at a time. A glyph start goes from the idle state straight to the
// response state, which loads its result; a pixel write or read passes through a write or
// read state between them. A bitmap word steps through its glyph bits (up to 32, fewer when
// the glyph ends inside the word, none when no glyph is active) at one bit per cycle, except
// that every set, visible pixel takes an extra blend state when fg_alpha is below opaque,
// because each blend registers the buffer pixel that it reads before writing it back. The
// result shows on the response channel the cycle after it is loaded. The result register
// lets a new request enter while the previous result still waits on the response channel;
// the new result then holds the block until that previous one is taken. The buffer is
// undefined after reset and needs no clearing. Write configuration only while no request
// is in flight.
`timescale 1ns / 1ps

module glyph_blit_alpha_blend #(
    parameter int FRAG_WIDTH  = 240,
    parameter int FRAG_HEIGHT = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [gba_pkg::C_CFG_DATA_W-1:0]  i_cfg_data,
    gba_req_if.sink                           i_req,
    gba_rsp_if.source                         o_rsp
);

    gba_pkg::t_cmd    cmd;
    gba_pkg::t_status sts;

    gba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    gba_datapath #(
        .FRAG_WIDTH  (FRAG_WIDTH),
        .FRAG_HEIGHT (FRAG_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req.req_type),
        .i_glyph_x      (i_req.glyph_x),
        .i_glyph_y      (i_req.glyph_y),
        .i_glyph_width  (i_req.glyph_width),
        .i_glyph_height (i_req.glyph_height),
        .i_bitmap_word  (i_req.bitmap_word),
        .i_pixel_addr   (i_req.pixel_addr),
        .i_pixel_value  (i_req.pixel_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_read_data    (o_rsp.read_data),
        .o_glyph_done   (o_rsp.glyph_done),
        .o_word_ignored (o_rsp.word_ignored)
    );

endmodule

// File: rtl/gba_checker.sv
// Port-level checker for the glyph blit block, bound to the top level.
`timescale 1ns / 1ps

module gba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [15:0] i_read_data,
    input logic        i_glyph_done,
    input logic        i_word_ignored
);

    // one request in flight: accepting a transaction closes the request side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while previous one in flight");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_glyph_done && i_word_ignored))
        else $error("glyph_done and word_ignored both set");

    a_flags_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_glyph_done || i_word_ignored)) |-> (i_read_data == 16'd0))
        else $error("bitmap word result carries read data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_read_data) && $stable(i_glyph_done)
             && $stable(i_word_ignored)))
        else $error("stalled response changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind glyph_blit_alpha_blend gba_checker u_gba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_read_data    (o_rsp.read_data),
    .i_glyph_done   (o_rsp.glyph_done),
    .i_word_ignored (o_rsp.word_ignored)
);
